// ----- design/damped_wave_grid_engine_core_macros.svh -----
// Assertion macros shared by the damped wave grid engine RTL.
// No dependencies; included by the files that carry assertions.
`ifndef DAMPED_WAVE_GRID_ENGINE_CORE_MACROS_SVH
`define DAMPED_WAVE_GRID_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, reset masks the check
`define DWG_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dwg assertion failed");

// Next-cycle implication, reset masks the check
`define DWG_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dwg assertion failed");

`endif

// ----- design/dwg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants for the damped wave grid engine.
// No dependencies; used by dwg_ctrl, dwg_dp and the top level.
package dwg_pkg;

  // Default grid size
  localparam int GRID_W_DEF = 256;
  localparam int GRID_H_DEF = 256;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_DAMPING    = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SHADE_GAIN = 1'd1;
  localparam logic [15:0] DAMPING_RST    = 16'd64881;
  localparam logic [11:0] SHADE_GAIN_RST = 12'd512;

  // Command codes
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_STEP  = 3'd0;
  localparam logic [OP_W-1:0] OP_POINT = 3'd1;
  localparam logic [OP_W-1:0] OP_STAMP = 3'd2;
  localparam logic [OP_W-1:0] OP_READ  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

  // Stream widths
  localparam int IN_DATA_W  = 32;  // x, y, intensity
  localparam int OUT_DATA_W = 72;  // shown, newest, shade

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic clr_start;
    logic clr_inc;
    logic scan_start;
    logic scan_rd0;
    logic scan_rd1;
    logic scan_rd2;
    logic scan_sum;
    logic scan_mul;
    logic scan_wr;
    logic swap;
    logic cell_start;
    logic cell_rd;
    logic cell_wr;
    logic cell_skip;
    logic rd_mul;
    logic out_load;
  } dwg_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            pt_ok;
    logic            st_ok;
    logic            rd_ok;
    logic            cell_in;
    logic            stamp_last;
    logic            scan_last;
    logic            clr_last;
  } dwg_sts_t;

  // 7x7 falloff kernel, signed Q2.16, by |dy| and |dx|
  function automatic logic signed [17:0] kern_weight(input logic [1:0] ady,
                                                     input logic [1:0] adx);
    logic signed [17:0] w;
    case ({ady, adx})
      4'b0000: w = 18'sd65536;
      4'b0001: w = 18'sd30440;
      4'b0010: w = -18'sd638;
      4'b0100: w = 18'sd30440;
      4'b0101: w = 18'sd14737;
      4'b0110: w = -18'sd3610;
      4'b1000: w = -18'sd638;
      4'b1001: w = -18'sd3610;
      4'b1010: w = -18'sd2391;
      default: w = 18'sd0;
    endcase
    return w;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sh07FFFFFFF) r = 32'h7FFF_FFFF;
    else if (v < -36'sh080000000) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- design/dwg_ctrl.sv -----
`timescale 1ns / 1ps
// Request sequencer of the damped wave grid engine.
// Depends on dwg_pkg and the shared assertion macros.
`include "damped_wave_grid_engine_core_macros.svh"
module dwg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  dwg_pkg::dwg_sts_t sts,
  output dwg_pkg::dwg_cmd_t cmd
);
  import dwg_pkg::*;

  typedef enum logic [14:0] {
    S_CLR      = 15'h0001,
    S_IDLE     = 15'h0002,
    S_DISP     = 15'h0004,
    S_STEP_RD0 = 15'h0008,
    S_STEP_RD1 = 15'h0010,
    S_STEP_RD2 = 15'h0020,
    S_STEP_SUM = 15'h0040,
    S_STEP_MUL = 15'h0080,
    S_STEP_WR  = 15'h0100,
    S_CELL_CHK = 15'h0200,
    S_CELL_RD  = 15'h0400,
    S_CELL_WR  = 15'h0800,
    S_READ_RD  = 15'h1000,
    S_READ_MUL = 15'h2000,
    S_DONE     = 15'h4000
  } state_t;

  state_t state, state_next;
  logic   clr_cmd, clr_cmd_next;
  logic   m_tvalid_next;

  assign s_tready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next   = state;
    clr_cmd_next = clr_cmd;
    cmd          = '0;
    case (state)
      S_CLR: begin
        cmd.clr_inc = 1'b1;
        if (sts.clr_last) begin
          state_next   = clr_cmd ? S_DONE : S_IDLE;
          clr_cmd_next = 1'b0;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          OP_STEP: begin
            cmd.scan_start = 1'b1;
            state_next     = S_STEP_RD0;
          end
          OP_POINT: begin
            cmd.cell_start = sts.pt_ok;
            state_next     = sts.pt_ok ? S_CELL_CHK : S_DONE;
          end
          OP_STAMP: begin
            cmd.cell_start = sts.st_ok;
            state_next     = sts.st_ok ? S_CELL_CHK : S_DONE;
          end
          OP_READ: begin
            cmd.cell_start = sts.rd_ok;
            state_next     = sts.rd_ok ? S_READ_RD : S_DONE;
          end
          OP_CLEAR: begin
            cmd.clr_start = 1'b1;
            clr_cmd_next  = 1'b1;
            state_next    = S_CLR;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_STEP_RD0: begin
        cmd.scan_rd0 = 1'b1;
        state_next   = S_STEP_RD1;
      end
      S_STEP_RD1: begin
        cmd.scan_rd1 = 1'b1;
        state_next   = S_STEP_RD2;
      end
      S_STEP_RD2: begin
        cmd.scan_rd2 = 1'b1;
        state_next   = S_STEP_SUM;
      end
      S_STEP_SUM: begin
        cmd.scan_sum = 1'b1;
        state_next   = S_STEP_MUL;
      end
      S_STEP_MUL: begin
        cmd.scan_mul = 1'b1;
        state_next   = S_STEP_WR;
      end
      S_STEP_WR: begin
        cmd.scan_wr = 1'b1;
        if (sts.scan_last) begin
          cmd.swap   = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_STEP_RD0;
        end
      end
      S_CELL_CHK: begin
        if (sts.cell_in) begin
          state_next = S_CELL_RD;
        end else begin
          cmd.cell_skip = 1'b1;
          state_next    = sts.stamp_last ? S_DONE : S_CELL_CHK;
        end
      end
      S_CELL_RD: begin
        cmd.cell_rd = 1'b1;
        state_next  = S_CELL_WR;
      end
      S_CELL_WR: begin
        cmd.cell_wr = 1'b1;
        state_next  = sts.stamp_last ? S_DONE : S_CELL_CHK;
      end
      S_READ_RD: state_next = S_READ_MUL;
      S_READ_MUL: begin
        cmd.rd_mul = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    if (cmd.out_load) m_tvalid_next = 1'b1;
    else if (m_tready) m_tvalid_next = 1'b0;
    else m_tvalid_next = m_tvalid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_cmd  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_cmd  <= clr_cmd_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  `DWG_ASSERT_NXT(a_accept_disp, clk, rst, s_tvalid && s_tready, state == S_DISP)
  `DWG_ASSERT_NXT(a_scan_end, clk, rst, state == S_STEP_WR && sts.scan_last, state == S_DONE)
  `DWG_ASSERT_NXT(a_clr_runs, clk, rst, state == S_CLR && !sts.clr_last, state == S_CLR)
  `DWG_ASSERT_NOW(a_load_free, clk, rst, cmd.out_load, !m_tvalid || m_tready)

endmodule

// ----- design/dwg_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the damped wave grid engine: frame memories, cell iterators,
// wave update arithmetic, cell writes, read shading and result registers. Uses dwg_pkg.
module dwg_dp #(
  parameter int GRID_W = dwg_pkg::GRID_W_DEF,
  parameter int GRID_H = dwg_pkg::GRID_H_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dwg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [dwg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [dwg_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [dwg_pkg::OP_W-1:0]          s_tuser,
  input  dwg_pkg::dwg_cmd_t                 cmd,
  output dwg_pkg::dwg_sts_t                 sts,
  output logic [dwg_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                              m_tuser
);
  import dwg_pkg::*;

  localparam int CELLS = GRID_W * GRID_H;
  localparam int AW    = $clog2(CELLS);
  localparam int GMAX  = (GRID_W > GRID_H) ? GRID_W : GRID_H;
  localparam int CBITS = ($clog2(GMAX) > 8) ? $clog2(GMAX) : 8;
  localparam int CW    = CBITS + 2;
  localparam int LW    = AW + CW;

  localparam logic signed [CW-1:0] C_ONE  = CW'(1);
  localparam logic signed [CW-1:0] C_TWO  = CW'(2);
  localparam logic signed [CW-1:0] C_THR  = CW'(3);
  localparam logic signed [CW-1:0] X_IN   = CW'(GRID_W - 2);
  localparam logic signed [CW-1:0] Y_IN   = CW'(GRID_H - 2);
  localparam logic signed [CW-1:0] X_ST   = CW'(GRID_W - 3);
  localparam logic signed [CW-1:0] Y_ST   = CW'(GRID_H - 3);
  localparam logic signed [CW-1:0] X_LAST = CW'(GRID_W - 1);
  localparam logic signed [CW-1:0] Y_LAST = CW'(GRID_H - 1);
  localparam logic [AW-1:0] A_ONE  = AW'(1);
  localparam logic [AW-1:0] A_ROW  = AW'(GRID_W);
  localparam logic [AW-1:0] A_LAST = AW'(CELLS - 1);

  // Configuration registers
  logic [15:0] damping;
  logic [11:0] shade_gain;

  // Request registers
  logic [OP_W-1:0]    op_q;
  logic [7:0]         x_q, y_q;
  logic signed [15:0] inten_q;

  // Iterators
  logic signed [CW-1:0] cur_x, cur_y;
  logic signed [2:0]    sdx, sdy;
  logic [AW-1:0]        clr_addr;
  logic                 newest_is_b;

  // Frame memories
  logic [31:0]   mem_a [CELLS];
  logic [31:0]   mem_b [CELLS];
  logic [AW-1:0] a_ra0, a_ra1, b_ra0, b_ra1, wa_a, wa_b;
  logic [31:0]   a_d0, a_d1, b_d0, b_d1, wd_a, wd_b;
  logic          we_a, we_b;

  // Arithmetic
  logic signed [35:0] p1, p2, v_q;
  logic signed [52:0] prod_q, prod_rnd;
  logic signed [34:0] step_sh;
  logic [31:0]        step_res, cell_res;
  logic signed [33:0] kprod, amt_q, amt_stamp, amt_point;
  logic signed [17:0] kw;
  logic [1:0]         adx, ady;
  logic [31:0]        mag, hs_q, hn_q;
  logic [43:0]        shade_prod;
  logic [27:0]        dark;
  logic [7:0]         dark_clip;

  // Output registers
  logic [31:0] out_shown, out_newest;
  logic [7:0]  out_shade;
  logic        out_acc;
  logic [31:0] out_shown_next, out_newest_next;
  logic [7:0]  out_shade_next;
  logic        out_acc_next;

  logic signed [CW-1:0] xe, ye;
  logic [LW-1:0]        lin_full;
  logic [AW-1:0]        cell_addr, nra0, nra1, ora;
  logic [31:0]          nd0, nd1, od0;

  // Coordinates of the request and of the current cell
  assign xe        = CW'(x_q);
  assign ye        = CW'(y_q);
  assign lin_full  = LW'(cur_y) * LW'(GRID_W) + LW'(cur_x);
  assign cell_addr = lin_full[AW-1:0];

  // Status
  assign sts.op         = op_q;
  assign sts.pt_ok      = xe >= C_ONE && xe <= X_IN && ye >= C_ONE && ye <= Y_IN;
  assign sts.st_ok      = xe >= C_TWO && xe <= X_ST && ye >= C_TWO && ye <= Y_ST;
  assign sts.rd_ok      = xe <= X_LAST && ye <= Y_LAST;
  assign sts.cell_in    = cur_x >= C_ONE && cur_x <= X_IN && cur_y >= C_ONE && cur_y <= Y_IN;
  assign sts.stamp_last = sdx == 3'sd3 && sdy == 3'sd3;
  assign sts.scan_last  = cur_x == X_IN && cur_y == Y_IN;
  assign sts.clr_last   = clr_addr == A_LAST;

  // Read addresses by role
  always_comb begin
    nra0 = cell_addr;
    nra1 = cell_addr;
    ora  = cell_addr;
    if (cmd.scan_rd0) begin
      nra0 = cell_addr - A_ONE;
      nra1 = cell_addr + A_ONE;
    end else if (cmd.scan_rd1) begin
      nra0 = cell_addr - A_ROW;
      nra1 = cell_addr + A_ROW;
    end
  end

  assign a_ra0 = newest_is_b ? ora : nra0;
  assign a_ra1 = nra1;
  assign b_ra0 = newest_is_b ? nra0 : ora;
  assign b_ra1 = nra1;
  assign nd0   = newest_is_b ? b_d0 : a_d0;
  assign nd1   = newest_is_b ? b_d1 : a_d1;
  assign od0   = newest_is_b ? a_d0 : b_d0;

  // Write ports: step writes older, cell ops write newest, clear writes both
  assign we_a = cmd.clr_inc | (cmd.scan_wr & newest_is_b) | (cmd.cell_wr & ~newest_is_b);
  assign we_b = cmd.clr_inc | (cmd.scan_wr & ~newest_is_b) | (cmd.cell_wr & newest_is_b);
  assign wa_a = cmd.clr_inc ? clr_addr : cell_addr;
  assign wa_b = cmd.clr_inc ? clr_addr : cell_addr;
  assign wd_a = cmd.clr_inc ? 32'd0 : (cmd.scan_wr ? step_res : cell_res);
  assign wd_b = wd_a;

  always_ff @(posedge clk) begin
    if (we_a) mem_a[wa_a] <= wd_a;
    a_d0 <= mem_a[a_ra0];
    a_d1 <= mem_a[a_ra1];
  end

  always_ff @(posedge clk) begin
    if (we_b) mem_b[wa_b] <= wd_b;
    b_d0 <= mem_b[b_ra0];
    b_d1 <= mem_b[b_ra1];
  end

  // Wave update: round, floor shift, clamp
  assign prod_rnd = prod_q + 53'sd131072;
  assign step_sh  = 35'(prod_rnd >>> 18);
  assign step_res = sat32(36'(step_sh));

  // Cell amounts
  assign ady       = sdy[2] ? 2'(-sdy) : sdy[1:0];
  assign adx       = sdx[2] ? 2'(-sdx) : sdx[1:0];
  assign kw        = kern_weight(ady, adx);
  assign kprod     = inten_q * kw;
  assign amt_stamp = (kprod + 34'sd128) >>> 8;
  assign amt_point = 34'(inten_q) <<< 8;
  assign cell_res  = sat32(36'($signed(nd0)) + 36'(amt_q));

  // Read shading
  assign mag       = od0[31] ? (~od0 + 32'd1) : od0;
  assign dark      = shade_prod[43:16];
  assign dark_clip = (|dark[27:8]) ? 8'd255 : dark[7:0];

  // Result fields by command
  always_comb begin
    out_shown_next  = '0;
    out_newest_next = '0;
    out_shade_next  = '0;
    out_acc_next    = 1'b0;
    case (op_q)
      OP_STEP:  out_acc_next = 1'b1;
      OP_CLEAR: out_acc_next = 1'b1;
      OP_POINT: out_acc_next = sts.pt_ok;
      OP_STAMP: out_acc_next = sts.st_ok;
      OP_READ: begin
        out_acc_next   = sts.rd_ok;
        out_shade_next = 8'd255;
        if (sts.rd_ok) begin
          out_shown_next  = hs_q;
          out_newest_next = hn_q;
          out_shade_next  = 8'd255 - dark_clip;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      damping     <= DAMPING_RST;
      shade_gain  <= SHADE_GAIN_RST;
      clr_addr    <= '0;
      newest_is_b <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_DAMPING:    damping    <= cfg_data;
          REG_SHADE_GAIN: shade_gain <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (cmd.clr_start) clr_addr <= '0;
      else if (cmd.clr_inc) clr_addr <= clr_addr + A_ONE;
      if (cmd.swap) newest_is_b <= ~newest_is_b;
    end
  end

  // Request latch, iterators, arithmetic pipeline and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= s_tuser;
      x_q     <= s_tdata[7:0];
      y_q     <= s_tdata[15:8];
      inten_q <= s_tdata[31:16];
    end
    if (cmd.scan_start) begin
      cur_x <= C_ONE;
      cur_y <= C_ONE;
    end else if (cmd.scan_wr) begin
      if (cur_x == X_IN) begin
        cur_x <= C_ONE;
        cur_y <= cur_y + C_ONE;
      end else begin
        cur_x <= cur_x + C_ONE;
      end
    end else if (cmd.cell_start) begin
      if (op_q == OP_STAMP) begin
        cur_x <= xe - C_THR;
        cur_y <= ye - C_THR;
        sdx   <= -3'sd3;
        sdy   <= -3'sd3;
      end else begin
        cur_x <= xe;
        cur_y <= ye;
        sdx   <= 3'sd3;
        sdy   <= 3'sd3;
      end
    end else if (cmd.cell_wr || cmd.cell_skip) begin
      if (sdx == 3'sd3) begin
        sdx   <= -3'sd3;
        cur_x <= xe - C_THR;
        sdy   <= sdy + 3'sd1;
        cur_y <= cur_y + C_ONE;
      end else begin
        sdx   <= sdx + 3'sd1;
        cur_x <= cur_x + C_ONE;
      end
    end
    if (cmd.scan_rd1) p1 <= 36'($signed(nd0)) + 36'($signed(nd1)) - (36'($signed(od0)) <<< 2);
    if (cmd.scan_rd2) p2 <= p1 + 36'($signed(nd0)) + 36'($signed(nd1));
    if (cmd.scan_sum) v_q <= p2 + (36'($signed(nd0)) <<< 2);
    if (cmd.scan_mul) prod_q <= 53'(v_q) * 53'($signed({1'b0, damping}));
    if (cmd.cell_rd) amt_q <= (op_q == OP_STAMP) ? amt_stamp : amt_point;
    if (cmd.rd_mul) begin
      hs_q       <= od0;
      hn_q       <= nd0;
      shade_prod <= 44'(mag) * 44'(shade_gain);
    end
    if (cmd.out_load) begin
      out_shown  <= out_shown_next;
      out_newest <= out_newest_next;
      out_shade  <= out_shade_next;
      out_acc    <= out_acc_next;
    end
  end

  assign m_tdata = {out_shade, out_newest, out_shown};
  assign m_tuser = out_acc;

endmodule

// ----- design/damped_wave_grid_engine_core.sv -----
`timescale 1ns / 1ps
// One request at a time. Step: each interior cell passes in turn through the read, sum,
// multiply and write states over the frame memory read ports. Point, read, stamp and
// clear each finish the same way; the result then sits in an output register.
// Reset: a clearing pass over every cell address zeroes both frames with s_tready low;
// configuration writes are taken throughout.
module damped_wave_grid_engine_core #(
  parameter int GRID_W = dwg_pkg::GRID_W_DEF,
  parameter int GRID_H = dwg_pkg::GRID_H_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dwg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [dwg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dwg_pkg::IN_DATA_W-1:0]  s_tdata,   // x[7:0], y[15:8], intensity[31:16]
  input  logic [dwg_pkg::OP_W-1:0]       s_tuser,   // op[2:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dwg_pkg::OUT_DATA_W-1:0] m_tdata,   // shown[31:0], newest[63:32], shade[71:64]
  output logic                           m_tuser    // accepted[0]
);
  import dwg_pkg::*;

  dwg_cmd_t cmd;
  dwg_sts_t sts;

  // Sequencer
  dwg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Frames and arithmetic
  dwg_dp #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
